### rtl/irclt_pkg.sv
// irclt_pkg: shared types and constants of the IRC line tokenizer.
// Used by irclt_parse, irclt_outq, irc_line_tokenizer and the testbench; depends on nothing.
`default_nettype none

package irclt_pkg;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	localparam logic [2:0] KIND_PREFIX = 3'd0;
	localparam logic [2:0] KIND_CMD    = 3'd1;
	localparam logic [2:0] KIND_MIDDLE = 3'd2;
	localparam logic [2:0] KIND_TRAIL  = 3'd3;
	localparam logic [2:0] KIND_END    = 3'd4;

	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
	localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic [2:0] kind;
		logic [7:0] param_index;
		logic       token_start;
		logic       line_bad;
		logic [7:0] param_total;
	} res_t;

	function automatic res_t mk_res(logic [7:0] b, logic [2:0] k, logic [7:0] idx,
		logic st, logic bad, logic [7:0] tot);
		res_t r;
		r.data_byte   = b;
		r.kind        = k;
		r.param_index = idx;
		r.token_start = st;
		r.line_bad    = bad;
		r.param_total = tot;
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/irc_line_tokenizer.sv
// irc_line_tokenizer: top level; input register, line parser, result queue.
// Depends on irclt_pkg, irclt_parse and irclt_outq.
//
// Input channel: in_valid/in_ready with rx_byte, one received byte per
// transaction. Output channel: out_valid/out_ready with data_byte, kind,
// param_index, token_start, line_bad and param_total, one result per
// transaction. LF ends a line, a CR right before LF is dropped, empty lines
// give nothing, and each other line closes with a line-end result.
// A byte is first registered in the input register, and its results are then
// written into the result queue, whose head drives the output channel.
// Throughput: one byte per cycle; one result per cycle while out_ready is high.
// A byte can yield two results (a held CR followed by a byte other than LF),
// so input is throttled only when the four-entry result queue runs short.
// Reset clears the line state, the input register and the queue. When the
// receiver stalls, results wait in the queue and in_ready drops once fewer
// than two queue slots would remain free.
`default_nettype none

module irc_line_tokenizer #(
	parameter int unsigned PARAM_COUNT_MAX = 255
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [7:0] rx_byte,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] data_byte,
	output logic [2:0] kind,
	output logic [7:0] param_index,
	output logic       token_start,
	output logic       line_bad,
	output logic [7:0] param_total
);

	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	logic                        adv;
	logic [1:0]                  res_n;
	logic [1:0]                  push_n;
	irclt_pkg::res_t             res_a, res_b, head;
	logic [irclt_pkg::Q_CW-1:0]  count;

	assign adv      = valid_s1 &&
		(count <= irclt_pkg::Q_CW'(irclt_pkg::Q_DEPTH - 2));
	assign in_ready = !valid_s1 || adv;
	assign push_n   = adv ? res_n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) byte_s1 <= rx_byte;
	end

	irclt_parse #(
		.PARAM_COUNT_MAX(PARAM_COUNT_MAX)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.rx_byte (byte_s1),
		.res_a   (res_a),
		.res_b   (res_b),
		.res_n   (res_n)
	);

	irclt_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (push_n),
		.push_a (res_a),
		.push_b (res_b),
		.pop    (out_valid && out_ready),
		.head   (head),
		.count  (count)
	);

	assign out_valid   = (count != '0);
	assign data_byte   = head.data_byte;
	assign kind        = head.kind;
	assign param_index = head.param_index;
	assign token_start = head.token_start;
	assign line_bad    = head.line_bad;
	assign param_total = head.param_total;

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		count <= irclt_pkg::Q_CW'(irclt_pkg::Q_DEPTH))
		else $error("result queue overflow");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted byte not registered");

	a_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == irclt_pkg::KIND_END |->
			data_byte == 8'd0 && !token_start && param_index == 8'd0)
		else $error("malformed line-end result");

	a_bad_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_bad |-> kind == irclt_pkg::KIND_END && param_total == 8'd0)
		else $error("line_bad outside a clean line end");

endmodule

`default_nettype wire

### rtl/irclt_parse.sv
// irclt_parse: line state and per-byte field classification; yields up to two
// results per byte (held CR plus the byte itself). Depends on irclt_pkg.
`default_nettype none

module irclt_parse #(
	parameter int unsigned PARAM_COUNT_MAX = 255
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    step,
	input  wire  [7:0]             rx_byte,
	output irclt_pkg::res_t        res_a,
	output irclt_pkg::res_t        res_b,
	output logic [1:0]             res_n
);

	localparam logic [7:0] COUNT_CAP = 8'((PARAM_COUNT_MAX < 255) ? PARAM_COUNT_MAX : 255);

	typedef enum logic [2:0] {
		PH_START, PH_PREFIX, PH_PRECMD, PH_CMD, PH_GAP, PH_MIDDLE, PH_TRAIL, PH_BAD
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic       tok;
		logic [7:0] cnt;
	} ctx_t;

	typedef struct packed {
		ctx_t            ctx;
		logic            v;
		irclt_pkg::res_t r;
	} take_t;

	function automatic take_t take_byte(ctx_t c, logic [7:0] b);
		take_t      t;
		logic [7:0] up;
		logic [7:0] nc;
		logic [7:0] idx;
		t.ctx = c;
		t.v   = 1'b0;
		t.r   = '0;
		up    = (b >= irclt_pkg::CH_LC_A && b <= irclt_pkg::CH_LC_Z) ?
			b - irclt_pkg::CASE_OFS : b;
		nc    = (c.cnt < COUNT_CAP) ? c.cnt + 8'd1 : c.cnt;
		idx   = (c.cnt != 8'd0) ? c.cnt - 8'd1 : 8'd0;
		unique case (c.phase) inside
			PH_START: begin
				if (b == irclt_pkg::CH_COLON) begin
					t.ctx.phase = PH_PREFIX;
					t.ctx.tok   = 1'b0;
				end else if (b == irclt_pkg::CH_SPACE) begin
					t.ctx.phase = PH_PRECMD;
				end else begin
					t.ctx.phase = PH_CMD;
					t.v = 1'b1;
					t.r = irclt_pkg::mk_res(up, irclt_pkg::KIND_CMD, 8'd0, 1'b1, 1'b0, 8'd0);
				end
			end
			PH_PREFIX: begin
				if (b == irclt_pkg::CH_SPACE) begin
					t.ctx.phase = c.tok ? PH_PRECMD : PH_BAD;
				end else begin
					t.v = 1'b1;
					t.r = irclt_pkg::mk_res(b, irclt_pkg::KIND_PREFIX, 8'd0, !c.tok, 1'b0,
						8'd0);
					t.ctx.tok = 1'b1;
				end
			end
			PH_PRECMD, PH_CMD: begin
				if (b == irclt_pkg::CH_SPACE) begin
					if (c.phase == PH_CMD) t.ctx.phase = PH_GAP;
				end else begin
					t.ctx.phase = PH_CMD;
					t.v = 1'b1;
					t.r = irclt_pkg::mk_res(up, irclt_pkg::KIND_CMD, 8'd0,
						c.phase == PH_PRECMD, 1'b0, 8'd0);
				end
			end
			PH_GAP: begin
				if (b != irclt_pkg::CH_SPACE) begin
					t.ctx.cnt = nc;
					if (b == irclt_pkg::CH_COLON) begin
						t.ctx.phase = PH_TRAIL;
						t.ctx.tok   = 1'b0;
					end else begin
						t.ctx.phase = PH_MIDDLE;
						t.v = 1'b1;
						t.r = irclt_pkg::mk_res(b, irclt_pkg::KIND_MIDDLE, nc - 8'd1, 1'b1,
							1'b0, 8'd0);
					end
				end
			end
			PH_MIDDLE: begin
				if (b == irclt_pkg::CH_SPACE) begin
					t.ctx.phase = PH_GAP;
				end else begin
					t.v = 1'b1;
					t.r = irclt_pkg::mk_res(b, irclt_pkg::KIND_MIDDLE, idx, 1'b0, 1'b0, 8'd0);
				end
			end
			PH_TRAIL: begin
				t.v = 1'b1;
				t.r = irclt_pkg::mk_res(b, irclt_pkg::KIND_TRAIL, idx, !c.tok, 1'b0, 8'd0);
				t.ctx.tok = 1'b1;
			end
			PH_BAD: begin
			end
		endcase
		return t;
	endfunction

	ctx_t  ctx_q, ctx_d;
	logic  cr_held_q, cr_held_d;
	take_t t_cr, t_b;
	logic  bad;

	always_comb begin
		t_cr      = take_byte(ctx_q, irclt_pkg::CH_CR);
		t_b       = '0;
		ctx_d     = ctx_q;
		cr_held_d = cr_held_q;
		res_a     = '0;
		res_b     = '0;
		res_n     = 2'd0;
		bad       = (ctx_q.phase == PH_PREFIX) || (ctx_q.phase == PH_BAD);
		if (rx_byte == irclt_pkg::CH_LF) begin
			cr_held_d = 1'b0;
			ctx_d     = '{phase: PH_START, tok: 1'b0, cnt: 8'd0};
			if (ctx_q.phase != PH_START) begin
				res_n = 2'd1;
				res_a = irclt_pkg::mk_res(8'd0, irclt_pkg::KIND_END, 8'd0, 1'b0, bad,
					bad ? 8'd0 : ctx_q.cnt);
			end
		end else begin
			if (!cr_held_q) t_cr = '0;
			if (cr_held_q) ctx_d = t_cr.ctx;
			if (rx_byte == irclt_pkg::CH_CR) begin
				cr_held_d = 1'b1;
			end else begin
				cr_held_d = 1'b0;
				t_b   = take_byte(ctx_d, rx_byte);
				ctx_d = t_b.ctx;
			end
			res_n = 2'(t_cr.v) + 2'(t_b.v);
			res_a = t_cr.v ? t_cr.r : t_b.r;
			res_b = t_b.r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q     <= '{phase: PH_START, tok: 1'b0, cnt: 8'd0};
			cr_held_q <= 1'b0;
		end else if (step) begin
			ctx_q     <= ctx_d;
			cr_held_q <= cr_held_d;
		end
	end

endmodule

`default_nettype wire

### rtl/irclt_outq.sv
// irclt_outq: small result queue, takes up to two results per cycle and
// gives one per cycle. Depends on irclt_pkg.
`default_nettype none

module irclt_outq (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire  [1:0]                     push_n,
	input  irclt_pkg::res_t                push_a,
	input  irclt_pkg::res_t                push_b,
	input  wire                            pop,
	output irclt_pkg::res_t                head,
	output logic [irclt_pkg::Q_CW-1:0]     count
);

	irclt_pkg::res_t                mem [irclt_pkg::Q_DEPTH];
	logic [irclt_pkg::Q_AW-1:0]     wr_q, rd_q;
	logic [irclt_pkg::Q_CW-1:0]     count_q;
	logic [irclt_pkg::Q_AW-1:0]     wr_p1;

	assign wr_p1 = wr_q + irclt_pkg::Q_AW'(1);
	assign head  = mem[rd_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem[wr_q]  <= push_a;
		if (push_n == 2'd2) mem[wr_p1] <= push_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + irclt_pkg::Q_AW'(push_n);
			rd_q    <= rd_q + irclt_pkg::Q_AW'(pop);
			count_q <= count_q + irclt_pkg::Q_CW'(push_n) - irclt_pkg::Q_CW'(pop);
		end
	end

endmodule

`default_nettype wire

### tb/tb_irc_line_tokenizer.sv
// tb_irc_line_tokenizer: self-checking testbench for the IRC line tokenizer.
// Depends on irclt_pkg and irc_line_tokenizer; a scoreboard class predicts
// every token and line-end result and checks the output stream in order.
`default_nettype none

module tb_irc_line_tokenizer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned COUNT_MAX = 255;
	localparam int unsigned COUNT_CAP = (COUNT_MAX < 255) ? COUNT_MAX : 255;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BYTES = 360;
	localparam int SAT_PARAMS = 270;

	typedef enum logic [2:0] {
		LS_START, LS_PREFIX, LS_PRECMD, LS_CMD, LS_GAP, LS_MIDDLE, LS_TRAIL, LS_BAD
	} line_state_t;

	class tok_scoreboard;
		irclt_pkg::res_t pending_tokens[$];
		line_state_t state = LS_START;
		bit cr_pending = 1'b0;
		bit token_seen = 1'b0;
		logic [7:0] params_opened = '0;
		int errors = 0;
		int results_checked = 0;
		int lines_closed = 0;

		function void add(logic [7:0] b, logic [2:0] k, logic [7:0] idx, logic st,
			logic bad, logic [7:0] tot);
			irclt_pkg::res_t r;
			r.data_byte   = b;
			r.kind        = k;
			r.param_index = idx;
			r.token_start = st;
			r.line_bad    = bad;
			r.param_total = tot;
			pending_tokens.insert(pending_tokens.size(), r);
		endfunction

		function logic [7:0] param_slot();
			return (params_opened > 0) ? params_opened - 8'd1 : 8'd0;
		endfunction

		function void consume(logic [7:0] b);
			logic [7:0] up;
			logic st;
			up = (b >= irclt_pkg::CH_LC_A && b <= irclt_pkg::CH_LC_Z) ?
				b - irclt_pkg::CASE_OFS : b;
			case (state) inside
				LS_START: begin
					if (b == irclt_pkg::CH_COLON) begin
						state = LS_PREFIX;
						token_seen = 1'b0;
					end else if (b == irclt_pkg::CH_SPACE) begin
						state = LS_PRECMD;
					end else begin
						state = LS_CMD;
						add(up, irclt_pkg::KIND_CMD, 8'd0, 1'b1, 1'b0, 8'd0);
					end
				end
				LS_PREFIX: begin
					if (b == irclt_pkg::CH_SPACE) begin
						state = token_seen ? LS_PRECMD : LS_BAD;
					end else begin
						add(b, irclt_pkg::KIND_PREFIX, 8'd0, !token_seen, 1'b0, 8'd0);
						token_seen = 1'b1;
					end
				end
				LS_PRECMD, LS_CMD: begin
					if (b == irclt_pkg::CH_SPACE) begin
						if (state == LS_CMD)
							state = LS_GAP;
					end else begin
						st = (state == LS_PRECMD);
						state = LS_CMD;
						add(up, irclt_pkg::KIND_CMD, 8'd0, st, 1'b0, 8'd0);
					end
				end
				LS_GAP: begin
					if (b != irclt_pkg::CH_SPACE) begin
						if (params_opened < COUNT_CAP)
							params_opened++;
						if (b == irclt_pkg::CH_COLON) begin
							state = LS_TRAIL;
							token_seen = 1'b0;
						end else begin
							state = LS_MIDDLE;
							add(b, irclt_pkg::KIND_MIDDLE, param_slot(), 1'b1, 1'b0, 8'd0);
						end
					end
				end
				LS_MIDDLE: begin
					if (b == irclt_pkg::CH_SPACE)
						state = LS_GAP;
					else
						add(b, irclt_pkg::KIND_MIDDLE, param_slot(), 1'b0, 1'b0, 8'd0);
				end
				LS_TRAIL: begin
					add(b, irclt_pkg::KIND_TRAIL, param_slot(), !token_seen, 1'b0, 8'd0);
					token_seen = 1'b1;
				end
				default: ;
			endcase
		endfunction

		function void note_rx_byte(logic [7:0] b);
			logic bad;
			if (b == irclt_pkg::CH_LF) begin
				cr_pending = 1'b0;
				if (state != LS_START) begin
					bad = (state == LS_PREFIX) || (state == LS_BAD);
					add(8'd0, irclt_pkg::KIND_END, 8'd0, 1'b0, bad,
						bad ? 8'd0 : params_opened);
				end
				state = LS_START;
				token_seen = 1'b0;
				params_opened = '0;
				return;
			end
			if (cr_pending) begin
				cr_pending = 1'b0;
				consume(irclt_pkg::CH_CR);
			end
			if (b == irclt_pkg::CH_CR)
				cr_pending = 1'b1;
			else
				consume(b);
		endfunction

		function void compare_field(string name, logic [7:0] e, logic [7:0] g);
			if (e !== g) begin
				errors++;
				$display("%0t: %s mismatch: expected %0h, got %0h", $time, name, e, g);
			end
		endfunction

		function void check_result(irclt_pkg::res_t got);
			irclt_pkg::res_t want;
			if (pending_tokens.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, got %h", $time, got);
				return;
			end
			want = pending_tokens.pop_front();
			results_checked++;
			if (want.kind == irclt_pkg::KIND_END)
				lines_closed++;
			compare_field("data_byte", want.data_byte, got.data_byte);
			compare_field("kind", want.kind, got.kind);
			compare_field("param_index", want.param_index, got.param_index);
			compare_field("token_start", want.token_start, got.token_start);
			compare_field("line_bad", want.line_bad, got.line_bad);
			compare_field("param_total", want.param_total, got.param_total);
		endfunction

		function int outstanding();
			return pending_tokens.size();
		endfunction

		function void report_leftover();
			if (pending_tokens.size() != 0) begin
				errors += pending_tokens.size();
				$display("%0t: %0d results never arrived, oldest expected %h, got none",
					$time, pending_tokens.size(), pending_tokens[0]);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] data_byte;
	logic [2:0] kind;
	logic [7:0] param_index;
	logic       token_start;
	logic       line_bad;
	logic [7:0] param_total;

	tok_scoreboard sb;
	logic [7:0] tx_bytes[$];
	irclt_pkg::res_t seen_token;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int bytes_sent = 0;
	int cycles = 0;

	irc_line_tokenizer #(
		.PARAM_COUNT_MAX(COUNT_MAX)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.data_byte  (data_byte),
		.kind       (kind),
		.param_index(param_index),
		.token_start(token_start),
		.line_bad   (line_bad),
		.param_total(param_total)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				sb.outstanding());
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	assign seen_token = {data_byte, kind, param_index, token_start, line_bad, param_total};

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(seen_token);
	end

	function automatic void queue_byte(input logic [7:0] b);
		tx_bytes.insert(tx_bytes.size(), b);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_rx_byte(b);
		bytes_sent++;
	endtask

	task automatic flush_bytes();
		while (tx_bytes.size() != 0)
			send_byte(tx_bytes.pop_front());
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_byte(s[i]);
	endtask

	function automatic logic [7:0] any_byte();
		case ($urandom_range(0, 9))
			0: return irclt_pkg::CH_SPACE;
			1: return irclt_pkg::CH_COLON;
			2: return irclt_pkg::CH_CR;
			3: return irclt_pkg::CH_LF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] word_byte();
		logic [7:0] b;
		if ($urandom_range(0, 1) == 0) begin
			b = irclt_pkg::CH_LC_A + 8'($urandom_range(0, 25));
			return $urandom_range(0, 1) ? b - irclt_pkg::CASE_OFS : b;
		end
		do
			b = 8'($urandom_range(0, 255));
		while (b == irclt_pkg::CH_SPACE || b == irclt_pkg::CH_LF || b == irclt_pkg::CH_CR ||
			b == irclt_pkg::CH_COLON);
		return b;
	endfunction

	function automatic logic [7:0] trail_byte();
		logic [7:0] b;
		do
			b = any_byte();
		while (b == irclt_pkg::CH_LF);
		return b;
	endfunction

	task automatic push_word(input int lo, input int hi);
		repeat ($urandom_range(lo, hi))
			queue_byte(word_byte());
	endtask

	task automatic build_random_line();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 75) begin
			if ($urandom_range(0, 2) == 0) begin
				queue_byte(irclt_pkg::CH_COLON);
				push_word(1, 5);
				queue_byte(irclt_pkg::CH_SPACE);
			end
			if ($urandom_range(0, 7) == 0) begin
				queue_byte(irclt_pkg::CH_SPACE);
				if ($urandom_range(0, 1))
					queue_byte(irclt_pkg::CH_COLON);
			end
			push_word(1, 6);
			if ($urandom_range(0, 9) == 0)
				queue_byte(irclt_pkg::CH_COLON);
			repeat ($urandom_range(0, 4)) begin
				queue_byte(irclt_pkg::CH_SPACE);
				if ($urandom_range(0, 5) == 0)
					queue_byte(irclt_pkg::CH_SPACE);
				push_word(1, 5);
			end
			if ($urandom_range(0, 1)) begin
				queue_byte(irclt_pkg::CH_SPACE);
				queue_byte(irclt_pkg::CH_COLON);
				repeat ($urandom_range(0, 8))
					queue_byte(trail_byte());
			end
		end else if (pick < 85) begin
			repeat ($urandom_range(1, 12))
				queue_byte(any_byte());
		end else if (pick < 95) begin
			queue_byte(irclt_pkg::CH_COLON);
			case ($urandom_range(0, 2))
				0: begin
					queue_byte(irclt_pkg::CH_SPACE);
					repeat ($urandom_range(0, 6))
						queue_byte(trail_byte());
				end
				1: push_word(1, 4);
				default: begin
					push_word(1, 4);
					queue_byte(irclt_pkg::CH_SPACE);
				end
			endcase
		end else begin
			repeat ($urandom_range(0, 3))
				queue_byte(irclt_pkg::CH_SPACE);
		end
		if ($urandom_range(0, 1))
			queue_byte(irclt_pkg::CH_CR);
		queue_byte(irclt_pkg::CH_LF);
	endtask

	initial begin
		int phase_bytes;
		sb = new;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// prefix, mixed-case command, middle, trailing with 0xFF, CRLF
		push_text(":p cMd x :");
		queue_byte(8'hFF);
		queue_byte(irclt_pkg::CH_CR);
		queue_byte(irclt_pkg::CH_LF);
		push_text(": x");
		queue_byte(irclt_pkg::CH_LF);
		push_text(":q");
		queue_byte(irclt_pkg::CH_LF);
		// held CR followed by data
		push_text("a");
		queue_byte(irclt_pkg::CH_CR);
		push_text("b");
		queue_byte(irclt_pkg::CH_LF);
		// empty line after CR drop
		queue_byte(irclt_pkg::CH_CR);
		queue_byte(irclt_pkg::CH_LF);
		flush_bytes();

		// parameter count saturation
		push_text("c");
		repeat (SAT_PARAMS)
			push_text(" p");
		queue_byte(irclt_pkg::CH_LF);
		flush_bytes();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 65; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 65; end
				default: begin send_idle_pct = 6; stall_pct = 6; end
			endcase
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				build_random_line();
				phase_bytes += tx_bytes.size();
				flush_bytes();
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		sb.report_leftover();
		$display("Sent %0d bytes in four flow-control phases; checked %0d results,",
			bytes_sent, sb.results_checked);
		$display("%0d of them line ends, including a saturated parameter count.",
			sb.lines_closed);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
